### rtl/mrm_pkg.sv
`default_nettype none

package mrm_pkg;

    // table geometry
    localparam int ENTRIES     = 16;
    localparam int NUM_MAPS    = 3;
    localparam int ADDR_BITS   = 32;
    localparam int HANDLE_BITS = 16;
    localparam int IDX_BITS    = $clog2(ENTRIES);
    localparam int CNT_BITS    = $clog2(ENTRIES + 1);
    localparam int MAP_BITS    = 2;
    localparam int RAM_DEPTH   = NUM_MAPS * (2 ** IDX_BITS);
    localparam int RAM_AW      = MAP_BITS + IDX_BITS;

    // request commands
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_ATTACH = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_ZERO_SIZE  = 3'd1,
        STS_BAD_MASK   = 3'd2,
        STS_OVERLAP    = 3'd3,
        STS_FULL       = 3'd4,
        STS_UNMAPPED   = 3'd5,
        STS_MISALIGNED = 3'd6,
        STS_WRAP       = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RD,
        S_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INSERT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]             command;
        logic [2:0]             access_mask;
        logic [1:0]             map_select;
        logic [2:0]             level;
        logic [7:0]             space;
        logic [ADDR_BITS-1:0]   address;
        logic [31:0]            size;
        logic [HANDLE_BITS-1:0] target_handle;
    } t_req;

    typedef struct packed {
        t_status                status;
        logic                   hit;
        logic [3:0]             entry_index;
        logic [ADDR_BITS-1:0]   offset;
        logic [7:0]             hit_space;
        logic [2:0]             hit_level;
        logic [HANDLE_BITS-1:0] hit_handle;
    } t_rsp;

    // one stored region
    typedef struct packed {
        logic [2:0]             level;
        logic [7:0]             space;
        logic [ADDR_BITS-1:0]   base;
        logic [ADDR_BITS-1:0]   bound;
        logic [HANDLE_BITS-1:0] handle;
    } t_entry;

    // compare unit results for one stored region
    typedef struct packed {
        logic                 ahead;
        logic                 overlap;
        logic                 contains;
        logic [ADDR_BITS-1:0] offset;
    } t_cmp;

endpackage

`default_nettype wire

### rtl/mrm_ram.sv
`default_nettype none

module mrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/mrm_cmp.sv
`default_nettype none

module mrm_cmp (
    input  wire mrm_pkg::t_entry                i_entry,
    input  wire logic [2:0]                     i_level,
    input  wire logic [mrm_pkg::ADDR_BITS-1:0]  i_addr,
    input  wire logic [mrm_pkg::ADDR_BITS-1:0]  i_end,
    output mrm_pkg::t_cmp                       o_cmp
);

    // stored region sorts ahead of the new one
    assign o_cmp.ahead = (i_entry.level < i_level) ||
                         ((i_entry.level == i_level) && (i_entry.bound < i_addr));

    // same level region starting at or below the new last byte
    assign o_cmp.overlap = (i_entry.level == i_level) && (i_entry.base <= i_end);

    // whole access inside the stored region
    assign o_cmp.contains = (i_addr >= i_entry.base) && (i_end <= i_entry.bound);

    assign o_cmp.offset = i_addr - i_entry.base;

endmodule

`default_nettype wire

### rtl/memory_region_map_core.sv
`default_nettype none

// Region map: read, write and execute tables of up to 16 regions each, kept
// sorted by level and then by address in one shared entry RAM.
// Request channel i_valid/o_ready carries i_req; response channel
// o_valid/i_ready carries o_rsp, exactly one response per request.
// o_ready is high only while the sequencer is idle; one request is worked
// on at a time, and the next may be taken while the last response waits.
// Flow: clear, an unknown command or a request failing the range checks
// goes straight to the response. A lookup reads the entries of the selected
// table in turn, each read followed by a compare, until one contains the
// access (hit) or the table ends (unmapped). An attach scans each selected
// table in the same way for its insert point, stopping on an overlap or a
// full table; once all tables pass, per table it moves the entries above the
// insert point up one slot, reading then writing each, and writes the new
// region.
// Reset clears the fill counts (all tables empty) and drops any pending
// response; entry contents are not cleared. When the receiver stalls the
// response holds in the output register and the sequencer waits in its
// final state with the next result until the register frees.
module memory_region_map_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire mrm_pkg::t_req i_req,
    output logic               o_valid,
    input  wire logic          i_ready,
    output mrm_pkg::t_rsp      o_rsp
);

    localparam int CB = mrm_pkg::CNT_BITS;
    localparam int IB = mrm_pkg::IDX_BITS;
    localparam int MB = mrm_pkg::MAP_BITS;
    localparam int NM = mrm_pkg::NUM_MAPS;

    mrm_pkg::t_state r_state, n_state;
    mrm_pkg::t_req   r_req, n_req;
    mrm_pkg::t_rsp   r_res, n_res;
    mrm_pkg::t_rsp   r_out, n_out;
    logic            r_out_valid, n_out_valid;
    logic [mrm_pkg::ADDR_BITS-1:0] r_end, n_end;
    logic [MB-1:0]   r_map, n_map;
    logic [CB-1:0]   r_idx, n_idx;
    logic [CB-1:0]   r_count [NM];
    logic [CB-1:0]   n_count [NM];
    logic [CB-1:0]   r_pos [NM];
    logic [CB-1:0]   n_pos [NM];

    logic                      ram_we;
    logic [mrm_pkg::RAM_AW-1:0] ram_waddr;
    mrm_pkg::t_entry           ram_wdata;
    logic                      ram_re;
    logic [mrm_pkg::RAM_AW-1:0] ram_raddr;
    mrm_pkg::t_entry           rd_data;
    mrm_pkg::t_entry           new_entry;
    mrm_pkg::t_cmp             cmp;

    logic [mrm_pkg::ADDR_BITS:0] end_full;
    logic                        size_zero;
    logic                        wrap;
    logic                        misalign;
    logic [31:0]                 size_m1;
    logic [MB-1:0]               first_map;
    logic [MB-1:0]               next_map;
    logic                        next_found;
    logic                        do_place;
    logic [CB-1:0]               idx_m1;

    // entry store
    mrm_ram #(
        .WIDTH ($bits(mrm_pkg::t_entry)),
        .DEPTH (mrm_pkg::RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    // shared compare unit
    mrm_cmp u_cmp (
        .i_entry (rd_data),
        .i_level (r_req.level),
        .i_addr  (r_req.address),
        .i_end   (r_end),
        .o_cmp   (cmp)
    );

    // request range checks
    assign size_m1   = r_req.size - 32'd1;
    assign end_full  = {1'b0, r_req.address} + {1'b0, r_req.size} -
                       {{mrm_pkg::ADDR_BITS{1'b0}}, 1'b1};
    assign size_zero = (r_req.size == 32'd0);
    assign wrap      = end_full[mrm_pkg::ADDR_BITS];
    assign misalign  = ((r_req.size & size_m1) != 32'd0) ||
                       ((r_req.address & size_m1) != '0);
    assign idx_m1    = r_idx - CB'(1);

    assign new_entry.level  = r_req.level;
    assign new_entry.space  = r_req.space;
    assign new_entry.base   = r_req.address;
    assign new_entry.bound  = r_end;
    assign new_entry.handle = r_req.target_handle;

    // first selected table and the next one after the current table
    always_comb begin
        first_map  = '0;
        next_map   = '0;
        next_found = 1'b0;
        for (int m = NM - 1; m >= 0; m--) begin
            if (r_req.access_mask[m]) begin
                first_map = MB'(m);
            end
            if (r_req.access_mask[m] && (MB'(m) > r_map)) begin
                next_map   = MB'(m);
                next_found = 1'b1;
            end
        end
    end

    assign o_ready = (r_state == mrm_pkg::S_IDLE);
    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_res       = r_res;
        n_end       = r_end;
        n_map       = r_map;
        n_idx       = r_idx;
        n_count     = r_count;
        n_pos       = r_pos;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        ram_we      = 1'b0;
        ram_waddr   = {r_map, r_idx[IB-1:0]};
        ram_wdata   = rd_data;
        ram_re      = 1'b0;
        ram_raddr   = {r_map, r_idx[IB-1:0]};
        do_place    = 1'b0;

        case (r_state)
            mrm_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_req   = i_req;
                    n_state = mrm_pkg::S_CHECK;
                end
            end
            mrm_pkg::S_CHECK: begin
                n_res        = '0;
                n_res.status = mrm_pkg::STS_OK;
                n_end        = end_full[mrm_pkg::ADDR_BITS-1:0];
                n_idx        = '0;
                n_state      = mrm_pkg::S_DONE;
                case (r_req.command)
                    mrm_pkg::CMD_CLEAR: begin
                        for (int m = 0; m < NM; m++) begin
                            n_count[m] = '0;
                        end
                    end
                    mrm_pkg::CMD_ATTACH: begin
                        if (size_zero) begin
                            n_res.status = mrm_pkg::STS_ZERO_SIZE;
                        end else if (r_req.access_mask == 3'd0) begin
                            n_res.status = mrm_pkg::STS_BAD_MASK;
                        end else if (wrap) begin
                            n_res.status = mrm_pkg::STS_WRAP;
                        end else begin
                            n_map   = first_map;
                            n_state = mrm_pkg::S_RD;
                        end
                    end
                    mrm_pkg::CMD_LOOKUP: begin
                        if (size_zero) begin
                            n_res.status = mrm_pkg::STS_ZERO_SIZE;
                        end else if (misalign) begin
                            n_res.status = mrm_pkg::STS_MISALIGNED;
                        end else if (wrap) begin
                            n_res.status = mrm_pkg::STS_WRAP;
                        end else if (r_req.map_select >= MB'(NM)) begin
                            n_res.status = mrm_pkg::STS_UNMAPPED;
                        end else begin
                            n_map   = r_req.map_select;
                            n_state = mrm_pkg::S_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            // fetch the next entry of the current table, or act on the end of the table
            mrm_pkg::S_RD: begin
                if (r_idx < r_count[r_map]) begin
                    ram_re  = 1'b1;
                    n_state = mrm_pkg::S_CMP;
                end else if (r_req.command == mrm_pkg::CMD_LOOKUP) begin
                    n_res.status = mrm_pkg::STS_UNMAPPED;
                    n_state      = mrm_pkg::S_DONE;
                end else begin
                    do_place = 1'b1;
                end
            end
            // judge the fetched entry
            mrm_pkg::S_CMP: begin
                if (r_req.command == mrm_pkg::CMD_LOOKUP) begin
                    if (cmp.contains) begin
                        n_res.status      = mrm_pkg::STS_OK;
                        n_res.hit         = 1'b1;
                        n_res.entry_index = 4'(r_idx);
                        n_res.offset      = cmp.offset;
                        n_res.hit_space   = rd_data.space;
                        n_res.hit_level   = rd_data.level;
                        n_res.hit_handle  = rd_data.handle;
                        n_state           = mrm_pkg::S_DONE;
                    end else begin
                        n_idx   = r_idx + CB'(1);
                        n_state = mrm_pkg::S_RD;
                    end
                end else if (cmp.ahead) begin
                    n_idx   = r_idx + CB'(1);
                    n_state = mrm_pkg::S_RD;
                end else if (cmp.overlap) begin
                    n_res.status = mrm_pkg::STS_OVERLAP;
                    n_state      = mrm_pkg::S_DONE;
                end else begin
                    do_place = 1'b1;
                end
            end
            // move entries up one slot, from the top down to the insert point
            mrm_pkg::S_SHIFT_RD: begin
                if (r_idx > r_pos[r_map]) begin
                    ram_re    = 1'b1;
                    ram_raddr = {r_map, idx_m1[IB-1:0]};
                    n_state   = mrm_pkg::S_SHIFT_WR;
                end else begin
                    n_state = mrm_pkg::S_INSERT;
                end
            end
            mrm_pkg::S_SHIFT_WR: begin
                ram_we  = 1'b1;
                n_idx   = idx_m1;
                n_state = mrm_pkg::S_SHIFT_RD;
            end
            // write the new region, then go on to the next selected table or finish
            mrm_pkg::S_INSERT: begin
                ram_we         = 1'b1;
                ram_waddr      = {r_map, r_pos[r_map][IB-1:0]};
                ram_wdata      = new_entry;
                n_count[r_map] = r_count[r_map] + CB'(1);
                if (next_found) begin
                    n_map   = next_map;
                    n_idx   = r_count[next_map];
                    n_state = mrm_pkg::S_SHIFT_RD;
                end else begin
                    n_res.status = mrm_pkg::STS_OK;
                    n_state      = mrm_pkg::S_DONE;
                end
            end
            mrm_pkg::S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = mrm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mrm_pkg::S_IDLE;
            end
        endcase

        // insert point found for this table: check room, then scan the next table or start the moves
        if (do_place) begin
            if (r_count[r_map] == CB'(mrm_pkg::ENTRIES)) begin
                n_res.status = mrm_pkg::STS_FULL;
                n_state      = mrm_pkg::S_DONE;
            end else begin
                n_pos[r_map] = r_idx;
                if (next_found) begin
                    n_map   = next_map;
                    n_idx   = '0;
                    n_state = mrm_pkg::S_RD;
                end else begin
                    n_map   = first_map;
                    n_idx   = r_count[first_map];
                    n_state = mrm_pkg::S_SHIFT_RD;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mrm_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            for (int m = 0; m < NM; m++) begin
                r_count[m] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_res <= n_res;
        r_out <= n_out;
        r_end <= n_end;
        r_map <= n_map;
        r_idx <= n_idx;
        r_pos <= n_pos;
    end

endmodule

`default_nettype wire
